// ===== rtl/core/bpm_pkg.sv =====
// bpm_pkg: types and constants shared by the byte pattern matcher.
// No dependencies; compile first.
`timescale 1ns / 1ps

package bpm_pkg;

	localparam int BYTE_W    = 8;
	localparam int IDX_W     = 7;
	localparam int LEN_W     = 8;
	localparam int SELF_W    = 32;
	localparam int ADDR_W    = 64;
	localparam int COUNT_W   = 32;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_W     = 64;

	typedef enum logic [1:0] {
		OP_LOAD  = 2'd0,
		OP_DATA  = 2'd1,
		OP_START = 2'd2
	} op_t;

	localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LENGTH = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SELF_OFFSET    = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SKIP_SELF      = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_BASE_ADDRESS   = 2'd3;

	localparam logic [LEN_W-1:0]  PATTERN_LENGTH_RST = 8'd1;
	localparam logic [SELF_W-1:0] SELF_OFFSET_RST    = '0;
	localparam logic              SKIP_SELF_RST      = 1'b1;
	localparam logic [ADDR_W-1:0] BASE_ADDRESS_RST   = '0;

	// broadcast to every cell of the chain
	typedef struct packed {
		logic              shift;
		logic              clear;
		logic [BYTE_W-1:0] din;
	} cell_ctl_t;

endpackage

// ===== rtl/core/bpm_if.sv =====
// bpm_if: valid/ready channels of the byte pattern matcher (item, result, config).
// Depends on bpm_pkg.
`timescale 1ns / 1ps

interface bpm_item_if;
	logic                          valid;
	logic                          ready;
	logic [1:0]                    opcode;
	logic [bpm_pkg::BYTE_W-1:0]    byte_value;
	logic [bpm_pkg::IDX_W-1:0]     pattern_index;

	modport source (output valid, opcode, byte_value, pattern_index, input ready);
	modport sink   (input valid, opcode, byte_value, pattern_index, output ready);
endinterface

interface bpm_result_if;
	logic                          valid;
	logic                          ready;
	logic [bpm_pkg::ADDR_W-1:0]    match_address;
	logic [bpm_pkg::COUNT_W-1:0]   match_number;

	modport source (output valid, match_address, match_number, input ready);
	modport sink   (input valid, match_address, match_number, output ready);
endinterface

interface bpm_cfg_if;
	logic                          valid;
	logic                          ready;
	logic [bpm_pkg::CFG_IDX_W-1:0] index;
	logic [bpm_pkg::CFG_W-1:0]     data;

	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/core/bpm_cell.sv =====
// bpm_cell: one pattern byte and one window byte of the compare chain.
// Depends on bpm_pkg.
`timescale 1ns / 1ps

module bpm_cell (
	input  logic                       clk,
	input  logic                       arst_n,
	input  bpm_pkg::cell_ctl_t         ctl,
	input  logic                       load,
	input  logic [bpm_pkg::BYTE_W-1:0] nbr,
	input  logic [bpm_pkg::BYTE_W-1:0] cmp,
	input  logic                       active,
	output logic [bpm_pkg::BYTE_W-1:0] win,
	output logic                       ok
);

	logic [bpm_pkg::BYTE_W-1:0] pat_q;
	logic [bpm_pkg::BYTE_W-1:0] win_q;

	always_ff @(posedge clk) begin
		if (load) begin
			pat_q <= ctl.din;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q <= '0;
		end else if (ctl.clear) begin
			win_q <= '0;
		end else if (ctl.shift) begin
			win_q <= nbr;
		end
	end

	assign win = win_q;
	assign ok  = !active || (cmp == pat_q);

endmodule

// ===== rtl/core/bpm_report.sv =====
// bpm_report: self-offset filter, saturating match count and result register.
// Depends on bpm_pkg and bpm_if.
`timescale 1ns / 1ps

module bpm_report #(
	parameter int OFFSET_BITS = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          up_valid,
	input  logic                          up_clear,
	input  logic                          up_hit,
	input  logic [OFFSET_BITS-1:0]        up_start,
	output logic                          up_ready,
	input  logic [bpm_pkg::SELF_W-1:0]    self_offset,
	input  logic                          skip_self,
	input  logic [bpm_pkg::ADDR_W-1:0]    base_address,
	bpm_result_if.source                  result
);

	localparam int CMP_W = (OFFSET_BITS > bpm_pkg::SELF_W) ? OFFSET_BITS : bpm_pkg::SELF_W;

	logic                           valid_s2;
	logic                           clear_s2;
	logic                           hit_s2;
	logic [OFFSET_BITS-1:0]         start_s2;
	logic [bpm_pkg::COUNT_W-1:0]    count_q;
	logic                           out_valid_q;
	logic [bpm_pkg::ADDR_W-1:0]     address_q;
	logic [bpm_pkg::COUNT_W-1:0]    number_q;

	logic                           out_free;
	logic                           is_self;
	logic                           emit;
	logic [bpm_pkg::COUNT_W-1:0]    count_next;

	assign out_free = !out_valid_q || result.ready;
	assign up_ready = !valid_s2 || out_free;

	assign is_self    = skip_self && (CMP_W'(start_s2) == CMP_W'(self_offset));
	assign emit       = valid_s2 && !clear_s2 && hit_s2 && !is_self;
	assign count_next = (count_q == '1) ? count_q : count_q + 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			clear_s2 <= 1'b0;
			hit_s2   <= 1'b0;
		end else if (up_ready) begin
			valid_s2 <= up_valid;
			clear_s2 <= up_clear;
			hit_s2   <= up_hit;
		end
	end

	always_ff @(posedge clk) begin
		if (up_ready) begin
			start_s2 <= up_start;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= emit;
			if (valid_s2 && clear_s2) begin
				count_q <= '0;
			end else if (emit) begin
				count_q <= count_next;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && emit) begin
			address_q <= base_address + bpm_pkg::ADDR_W'(start_s2);
			number_q  <= count_next;
		end
	end

	assign result.valid         = out_valid_q;
	assign result.match_address = address_q;
	assign result.match_number  = number_q;

endmodule

// ===== rtl/core/byte_pattern_matcher.sv =====
// byte_pattern_matcher: streaming search for a stored byte pattern, one byte per cycle.
// Depends on bpm_pkg, bpm_if, bpm_cell and bpm_report.
//
//   channel  dir  payload                                  accepted when
//   item     in   opcode, byte_value, pattern_index        item.valid & item.ready
//   result   out  match_address, match_number              result.valid & result.ready
//   cfg      in   index, data (pattern_length .. base)     cfg.valid & cfg.ready
//
// One item per cycle while item.ready is high; a match passes stages 1 and 2 to result.
// The cell chain shifts the byte window at the accept edge; stage 1 aligns the window to
// the pattern length and compares every cell in parallel, and the hit goes into stage 2,
// which filters, counts and loads the result register.
// Stalls on result back up through stage 2 and stage 1; item.ready drops only when
// all three are full. cfg.ready is always high. Reset clears window, fill, offset and
// count; pattern bytes are undefined until loaded.
`timescale 1ns / 1ps

module byte_pattern_matcher #(
	parameter int MAX_PATTERN = 128,
	parameter int OFFSET_BITS = 32
) (
	input  logic          clk,
	input  logic          arst_n,
	bpm_item_if.sink      item,
	bpm_result_if.source  result,
	bpm_cfg_if.sink       cfg
);

	localparam int CNT_W = $clog2(MAX_PATTERN + 1);
	localparam int SEL_W = (CNT_W > bpm_pkg::LEN_W) ? CNT_W : bpm_pkg::LEN_W;
	localparam int LG    = $clog2(bpm_pkg::BYTE_W);
	localparam int WIN_W = MAX_PATTERN * bpm_pkg::BYTE_W;

	logic [bpm_pkg::LEN_W-1:0]   pattern_length_q;
	logic [bpm_pkg::SELF_W-1:0]  self_offset_q;
	logic                        skip_self_q;
	logic [bpm_pkg::ADDR_W-1:0]  base_address_q;

	logic [OFFSET_BITS-1:0]      stream_offset_q;
	logic [CNT_W-1:0]            fill_q;
	logic                        valid_s1;
	logic                        clear_s1;
	logic [OFFSET_BITS-1:0]      start_s1;

	logic                        accept;
	logic                        acc_load;
	logic                        acc_data;
	logic                        acc_start;
	logic                        s2_ready;
	logic                        s1_free;
	logic                        len_ok;
	logic                        fill_ok;
	logic                        hit;
	bpm_pkg::cell_ctl_t          ctl;
	logic [SEL_W-1:0]            shamt;
	logic [SEL_W+LG-1:0]         bit_shift;
	logic [WIN_W-1:0]            wins;
	logic [WIN_W-1:0]            aligned;
	logic [MAX_PATTERN-1:0]      oks;

	assign s1_free    = !valid_s1 || s2_ready;
	assign item.ready = s1_free;
	assign cfg.ready  = 1'b1;

	assign accept    = item.valid && s1_free;
	assign acc_load  = accept && (item.opcode == bpm_pkg::OP_LOAD);
	assign acc_data  = accept && (item.opcode == bpm_pkg::OP_DATA);
	assign acc_start = accept && (item.opcode == bpm_pkg::OP_START);

	assign ctl.shift = acc_data;
	assign ctl.clear = acc_start;
	assign ctl.din   = item.byte_value;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pattern_length_q <= bpm_pkg::PATTERN_LENGTH_RST;
			self_offset_q    <= bpm_pkg::SELF_OFFSET_RST;
			skip_self_q      <= bpm_pkg::SKIP_SELF_RST;
			base_address_q   <= bpm_pkg::BASE_ADDRESS_RST;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				bpm_pkg::REG_PATTERN_LENGTH: pattern_length_q <= cfg.data[bpm_pkg::LEN_W-1:0];
				bpm_pkg::REG_SELF_OFFSET:    self_offset_q    <= cfg.data[bpm_pkg::SELF_W-1:0];
				bpm_pkg::REG_SKIP_SELF:      skip_self_q      <= cfg.data[0];
				bpm_pkg::REG_BASE_ADDRESS:   base_address_q   <= cfg.data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stream_offset_q <= '0;
			fill_q          <= '0;
			valid_s1        <= 1'b0;
			clear_s1        <= 1'b0;
		end else begin
			if (acc_start) begin
				stream_offset_q <= '0;
				fill_q          <= '0;
			end else if (acc_data) begin
				stream_offset_q <= stream_offset_q + 1'b1;
				if (fill_q != CNT_W'(MAX_PATTERN)) begin
					fill_q <= fill_q + 1'b1;
				end
			end
			if (s1_free) begin
				valid_s1 <= acc_data || acc_start;
				clear_s1 <= acc_start;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc_data) begin
			start_s1 <= stream_offset_q + 1'b1 - OFFSET_BITS'(pattern_length_q);
		end
	end

	assign shamt     = SEL_W'(MAX_PATTERN) - SEL_W'(pattern_length_q);
	assign bit_shift = {shamt, {LG{1'b0}}};
	assign aligned   = wins >> bit_shift;

	genvar j;
	generate
		for (j = 0; j < MAX_PATTERN; j++) begin : g_cell
			logic [bpm_pkg::BYTE_W-1:0] nbr;
			logic                       load;
			logic                       active;

			if (j == MAX_PATTERN - 1) begin : g_head
				assign nbr = item.byte_value;
			end else begin : g_link
				assign nbr = wins[(j+1)*bpm_pkg::BYTE_W +: bpm_pkg::BYTE_W];
			end

			assign load   = acc_load && (32'(item.pattern_index) == 32'(j));
			assign active = (SEL_W'(j) < SEL_W'(pattern_length_q));

			bpm_cell u_cell (
				.clk    (clk),
				.arst_n (arst_n),
				.ctl    (ctl),
				.load   (load),
				.nbr    (nbr),
				.cmp    (aligned[j*bpm_pkg::BYTE_W +: bpm_pkg::BYTE_W]),
				.active (active),
				.win    (wins[j*bpm_pkg::BYTE_W +: bpm_pkg::BYTE_W]),
				.ok     (oks[j])
			);
		end
	endgenerate

	assign len_ok  = (pattern_length_q != '0) && (SEL_W'(pattern_length_q) <= SEL_W'(MAX_PATTERN));
	assign fill_ok = (SEL_W'(fill_q) >= SEL_W'(pattern_length_q));
	assign hit     = len_ok && fill_ok && (&oks);

	bpm_report #(
		.OFFSET_BITS (OFFSET_BITS)
	) u_report (
		.clk          (clk),
		.arst_n       (arst_n),
		.up_valid     (valid_s1),
		.up_clear     (clear_s1),
		.up_hit       (hit),
		.up_start     (start_s1),
		.up_ready     (s2_ready),
		.self_offset  (self_offset_q),
		.skip_self    (skip_self_q),
		.base_address (base_address_q),
		.result       (result)
	);

	a_start_clears_fill : assert property (@(posedge clk) disable iff (!arst_n)
		acc_start |=> (fill_q == '0))
		else $error("window fill not cleared by start item");

	a_no_accept_when_full : assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !s2_ready) |-> !item.ready)
		else $error("item accepted while stage 1 is stalled");

	a_number_nonzero : assert property (@(posedge clk) disable iff (!arst_n)
		result.valid |-> (result.match_number != '0))
		else $error("result carries match number zero");

	a_data_advances_offset : assert property (@(posedge clk) disable iff (!arst_n)
		acc_data |=> (stream_offset_q == $past(stream_offset_q) + 1'b1))
		else $error("stream offset did not advance on data item");

endmodule

// ===== test/byte_pattern_matcher_tb.sv =====
// byte_pattern_matcher_tb: self-checking bench that scans byte streams for a loaded
// pattern and compares every reported match against a cycle-free predictor.
// Depends on bpm_pkg, bpm_if and the byte_pattern_matcher RTL.
`timescale 1ns / 1ps

class match_tracker;
	localparam int DEPTH = 128;

	typedef struct {
		logic [bpm_pkg::ADDR_W-1:0]  addr;
		logic [bpm_pkg::COUNT_W-1:0] num;
	} match_t;

	logic [bpm_pkg::BYTE_W-1:0]  pattern_bytes [DEPTH];
	logic [bpm_pkg::BYTE_W-1:0]  window [DEPTH];
	logic [bpm_pkg::SELF_W-1:0]  offset;
	logic [bpm_pkg::COUNT_W-1:0] found;
	int                          fill;

	logic [bpm_pkg::LEN_W-1:0]   pattern_len;
	logic [bpm_pkg::SELF_W-1:0]  self_offset;
	logic                        skip_self;
	logic [bpm_pkg::ADDR_W-1:0]  base;

	match_t expected[$];
	int     errors;

	function new();
		pattern_len = bpm_pkg::PATTERN_LENGTH_RST;
		self_offset = bpm_pkg::SELF_OFFSET_RST;
		skip_self   = bpm_pkg::SKIP_SELF_RST;
		base        = bpm_pkg::BASE_ADDRESS_RST;
		errors      = 0;
		foreach (pattern_bytes[i]) pattern_bytes[i] = '0;
		clear_scan();
	endfunction

	function void clear_scan();
		foreach (window[i]) window[i] = '0;
		offset = '0;
		found  = '0;
		fill   = 0;
	endfunction

	function int pending();
		return expected.size();
	endfunction

	// usable pattern length, zero when no match is possible
	function int match_len();
		return (pattern_len == 0 || pattern_len > DEPTH) ? 0 : int'(pattern_len);
	endfunction

	function void write_reg(logic [bpm_pkg::CFG_IDX_W-1:0] idx, logic [bpm_pkg::CFG_W-1:0] d);
		case (idx)
			bpm_pkg::REG_PATTERN_LENGTH: pattern_len = d[bpm_pkg::LEN_W-1:0];
			bpm_pkg::REG_SELF_OFFSET:    self_offset = d[bpm_pkg::SELF_W-1:0];
			bpm_pkg::REG_SKIP_SELF:      skip_self   = d[0];
			bpm_pkg::REG_BASE_ADDRESS:   base        = d[bpm_pkg::ADDR_W-1:0];
			default: ;
		endcase
	endfunction

	function void note_item(logic [1:0] op, logic [bpm_pkg::BYTE_W-1:0] b,
			logic [bpm_pkg::IDX_W-1:0] idx);
		logic [bpm_pkg::SELF_W-1:0] cur;
		logic [bpm_pkg::SELF_W-1:0] start;
		int                         len;
		match_t                     m;
		case (op)
			bpm_pkg::OP_LOAD: begin
				pattern_bytes[idx] = b;
			end
			bpm_pkg::OP_START: begin
				clear_scan();
			end
			bpm_pkg::OP_DATA: begin
				for (int i = 0; i < DEPTH - 1; i++) window[i] = window[i+1];
				window[DEPTH-1] = b;
				if (fill < DEPTH) fill++;
				cur    = offset;
				offset = cur + 1'b1;
				len    = match_len();
				if (len == 0 || fill < len) return;
				for (int i = 0; i < len; i++)
					if (window[DEPTH-len+i] != pattern_bytes[i]) return;
				start = cur + 1'b1 - bpm_pkg::SELF_W'(len);
				if (skip_self && start == self_offset) return;
				if (found != '1) found++;
				m.addr = base + bpm_pkg::ADDR_W'(start);
				m.num  = found;
				expected.insert(expected.size(), m);
			end
			default: ;
		endcase
	endfunction

	function void check_match(logic [bpm_pkg::ADDR_W-1:0] addr,
			logic [bpm_pkg::COUNT_W-1:0] num);
		match_t m;
		if (expected.size() == 0) begin
			$error("unexpected match: match_address %h, match_number %0d", addr, num);
			errors++;
			return;
		end
		m = expected.pop_front();
		if (addr !== m.addr) begin
			$error("match_address: expected %h, actual %h", m.addr, addr);
			errors++;
		end
		if (num !== m.num) begin
			$error("match_number: expected %0d, actual %0d", m.num, num);
			errors++;
		end
	endfunction
endclass

module byte_pattern_matcher_tb;

	localparam logic [1:0] OP_UNUSED = 2'd3;

	logic clk = 1'b0;
	logic arst_n;

	bpm_item_if   item_ch();
	bpm_result_if res_ch();
	bpm_cfg_if    cfg_ch();

	byte_pattern_matcher uut (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item_ch),
		.result (res_ch),
		.cfg    (cfg_ch)
	);

	match_tracker sb = new();

	int idle_pct  = 0;
	int stall_pct = 0;
	bit item_fire = 1'b0;
	bit cfg_fire  = 1'b0;

	always #5 clk = ~clk;

	always @(posedge clk) begin
		item_fire = arst_n && item_ch.valid && item_ch.ready;
		cfg_fire  = arst_n && cfg_ch.valid && cfg_ch.ready;
		if (arst_n && res_ch.valid && res_ch.ready)
			sb.check_match(res_ch.match_address, res_ch.match_number);
		if (item_fire)
			sb.note_item(item_ch.opcode, item_ch.byte_value, item_ch.pattern_index);
		if (cfg_fire)
			sb.write_reg(cfg_ch.index, cfg_ch.data);
	end

	always @(negedge clk) begin
		res_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
	end

	task automatic send_item(input logic [1:0] op, input logic [bpm_pkg::BYTE_W-1:0] b,
			input logic [bpm_pkg::IDX_W-1:0] idx);
		while ($urandom_range(0, 99) < idle_pct) begin
			item_ch.valid <= 1'b0;
			@(negedge clk);
		end
		item_ch.valid         <= 1'b1;
		item_ch.opcode        <= op;
		item_ch.byte_value    <= b;
		item_ch.pattern_index <= idx;
		do @(negedge clk); while (!item_fire);
	endtask

	task automatic write_reg(input logic [bpm_pkg::CFG_IDX_W-1:0] idx,
			input logic [bpm_pkg::CFG_W-1:0] d);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data  <= d;
		do @(negedge clk); while (!cfg_fire);
	endtask

	task automatic hold_until_drained();
		item_ch.valid <= 1'b0;
		do @(negedge clk); while (sb.pending() != 0);
	endtask

	task automatic quiesce();
		hold_until_drained();
		repeat (6) @(negedge clk);
	endtask

	task automatic configure(input logic [bpm_pkg::LEN_W-1:0] len,
			input logic [bpm_pkg::SELF_W-1:0] self_off,
			input logic skip, input logic [bpm_pkg::ADDR_W-1:0] base);
		quiesce();
		write_reg(bpm_pkg::REG_PATTERN_LENGTH, bpm_pkg::CFG_W'(len));
		write_reg(bpm_pkg::REG_SELF_OFFSET, bpm_pkg::CFG_W'(self_off));
		write_reg(bpm_pkg::REG_SKIP_SELF, bpm_pkg::CFG_W'(skip));
		write_reg(bpm_pkg::REG_BASE_ADDRESS, base);
		cfg_ch.valid <= 1'b0;
	endtask

	function automatic logic [bpm_pkg::BYTE_W-1:0] alpha_byte();
		case ($urandom_range(0, 4))
			0: return 8'h00;
			1: return 8'hFF;
			2: return 8'h5A;
			3: return 8'hA5;
			default: return bpm_pkg::BYTE_W'($urandom);
		endcase
	endfunction

	task automatic run_random(input int count);
		int                         sent;
		int                         r;
		int                         plen;
		logic [bpm_pkg::BYTE_W-1:0] b;
		sent = 0;
		while (sent < count) begin
			r    = $urandom_range(0, 99);
			plen = sb.match_len();
			if (r < 4) begin
				send_item(bpm_pkg::OP_START, bpm_pkg::BYTE_W'($urandom),
					bpm_pkg::IDX_W'($urandom));
				sent++;
			end else if (r < 7) begin
				send_item(OP_UNUSED, bpm_pkg::BYTE_W'($urandom), bpm_pkg::IDX_W'($urandom));
				sent++;
			end else if (r < 12) begin
				send_item(bpm_pkg::OP_LOAD, alpha_byte(), bpm_pkg::IDX_W'($urandom));
				sent++;
			end else if (r < 16 && plen > 0 && plen <= 8) begin
				for (int i = 0; i < plen; i++)
					send_item(bpm_pkg::OP_LOAD, alpha_byte(), bpm_pkg::IDX_W'(i));
				sent += plen;
			end else if (r < 18) begin
				hold_until_drained();
			end else if (r < 45 && plen > 0) begin
				for (int i = 0; i < plen; i++)
					send_item(bpm_pkg::OP_DATA, sb.pattern_bytes[i], bpm_pkg::IDX_W'($urandom));
				sent += plen;
			end else begin
				if (plen > 0 && $urandom_range(0, 1))
					b = sb.pattern_bytes[$urandom_range(0, plen - 1)];
				else
					b = alpha_byte();
				send_item(bpm_pkg::OP_DATA, b, bpm_pkg::IDX_W'($urandom));
				sent++;
			end
		end
	endtask

	initial begin
		int                          lens [10];
		logic [bpm_pkg::SELF_W-1:0]  self_off;
		logic                        skip;
		logic [bpm_pkg::ADDR_W-1:0]  base;

		lens = '{1, 3, 4, 2, 128, 0, 129, 6, 255, 1};

		arst_n                = 1'b0;
		item_ch.valid         = 1'b0;
		item_ch.opcode        = bpm_pkg::OP_LOAD;
		item_ch.byte_value    = '0;
		item_ch.pattern_index = '0;
		cfg_ch.valid          = 1'b0;
		cfg_ch.index          = bpm_pkg::REG_PATTERN_LENGTH;
		cfg_ch.data           = '0;
		res_ch.ready          = 1'b0;
		repeat (5) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// fill the whole pattern store before any compare
		for (int i = 0; i < 128; i++)
			send_item(bpm_pkg::OP_LOAD,
				(i == 0) ? 8'hFF : (i == 1) ? 8'h00 : bpm_pkg::BYTE_W'($urandom),
				bpm_pkg::IDX_W'(i));

		send_item(bpm_pkg::OP_DATA, 8'hFF, '0);
		send_item(bpm_pkg::OP_DATA, 8'h00, '1);
		send_item(bpm_pkg::OP_DATA, 8'hFF, '0);
		send_item(OP_UNUSED, 8'hFF, '1);
		send_item(bpm_pkg::OP_DATA, 8'hFF, '0);
		send_item(bpm_pkg::OP_START, 8'h00, '0);
		send_item(bpm_pkg::OP_DATA, 8'hFF, '1);
		send_item(bpm_pkg::OP_DATA, 8'hFF, '0);
		hold_until_drained();

		configure(8'd2, 32'd2, 1'b1, '1);
		send_item(bpm_pkg::OP_DATA, 8'hFF, '0);
		send_item(bpm_pkg::OP_DATA, 8'h00, '0);
		send_item(bpm_pkg::OP_DATA, 8'hFF, '0);
		send_item(bpm_pkg::OP_DATA, 8'h00, '0);
		send_item(bpm_pkg::OP_LOAD, 8'h80, '1);
		send_item(bpm_pkg::OP_DATA, 8'hFF, '0);
		send_item(bpm_pkg::OP_DATA, 8'h00, '0);

		for (int k = 0; k < 10; k++) begin
			case (k % 3)
				0: self_off = bpm_pkg::SELF_W'($urandom_range(0, 40));
				1: self_off = '1;
				default: self_off = bpm_pkg::SELF_W'($urandom);
			endcase
			skip = (k % 3 == 0) ? 1'b1 : 1'($urandom_range(0, 1));
			if (k == 0)
				base = '0;
			else if (k == 2)
				base = '1 - bpm_pkg::ADDR_W'($urandom_range(0, 255));
			else
				base = {32'($urandom), 32'($urandom)};
			configure(bpm_pkg::LEN_W'(lens[k]), self_off, skip, base);
			case (k % 4)
				0: begin idle_pct = 0;  stall_pct = 0;  end
				1: begin idle_pct = 83; stall_pct = 0;  end
				2: begin idle_pct = 0;  stall_pct = 83; end
				default: begin idle_pct = 30; stall_pct = 30; end
			endcase
			run_random((lens[k] == 128) ? 300 : 140);
		end

		idle_pct  = 0;
		stall_pct = 0;
		hold_until_drained();
		repeat (10) @(negedge clk);
		if (sb.errors == 0 && sb.pending() == 0)
			$display("byte_pattern_matcher_tb passed");
		else
			$display("byte_pattern_matcher_tb failed");
		$finish;
	end

	initial begin
		#5_000_000;
		$display("byte_pattern_matcher_tb failed");
		$finish;
	end

endmodule

// ===== files.f =====
rtl/core/bpm_pkg.sv
rtl/core/bpm_if.sv
rtl/core/bpm_cell.sv
rtl/core/bpm_report.sv
rtl/core/byte_pattern_matcher.sv
test/byte_pattern_matcher_tb.sv
